### hdl/lptr_pkg.sv
// Shared types, constants and codes of the long-press touch recognizer.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package lptr_pkg;

   // Table size and the bound on results from one tick.
   localparam int MAX_TOUCHES = 8;
   localparam int MAX_RESULTS = 8;

   localparam int SLOT_W = (MAX_TOUCHES > 1) ? $clog2(MAX_TOUCHES) : 1;
   localparam int CNT_W  = $clog2(MAX_RESULTS + 1);

   // Field widths.
   localparam int KIND_W     = 2;
   localparam int EVENT_W    = 3;
   localparam int ID_W       = 8;
   localparam int POS_W      = 12;
   localparam int CD_W       = 16;
   localparam int MOVE_W     = 12;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam int SQ_W       = 2 * POS_W;

   // Register reset values.
   localparam logic [MOVE_W-1:0] MAX_MOVE_RESET   = MOVE_W'(60);
   localparam logic [CD_W-1:0]   HOLD_TICKS_RESET = CD_W'(400);

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_MOVEMENT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_TICKS   = 1'b1;

   // Request kinds.
   localparam logic [KIND_W-1:0] REQ_BEGIN = 2'd0;
   localparam logic [KIND_W-1:0] REQ_MOVE  = 2'd1;
   localparam logic [KIND_W-1:0] REQ_END   = 2'd2;
   localparam logic [KIND_W-1:0] REQ_TICK  = 2'd3;

   // Result kinds.
   localparam logic [EVENT_W-1:0] EV_STARTED    = 3'd0;
   localparam logic [EVENT_W-1:0] EV_MOVED      = 3'd1;
   localparam logic [EVENT_W-1:0] EV_CANCELED   = 3'd2;
   localparam logic [EVENT_W-1:0] EV_RECOGNIZED = 3'd3;
   localparam logic [EVENT_W-1:0] EV_REJECTED   = 3'd4;

   typedef struct packed {
      logic [KIND_W-1:0] req_type;
      logic [ID_W-1:0]   touch_id;
      logic [POS_W-1:0]  pos_x;
      logic [POS_W-1:0]  pos_y;
   } req_item_type;

   typedef struct packed {
      logic [EVENT_W-1:0] event_kind;
      logic [ID_W-1:0]    event_id;
      logic [POS_W-1:0]   origin_x_out;
      logic [POS_W-1:0]   origin_y_out;
      logic               last_of_run;
   } rsp_item_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic scan;
      logic target;
      logic tick_step;
      logic apply;
      logic flush;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [KIND_W-1:0] req_kind;
      logic              cur_valid;
      logic              cur_cd_gt1;
      logic              cnt_full;
      logic              idx_last;
      logic              has_match;
      logic              pend_valid;
      logic              out_free;
   } dp_stat_type;

endpackage

### hdl/long_press_touch_recognizer_unit.sv
// Top level of the long-press touch recognizer: controller plus datapath.
// Depends on lptr_pkg, lptr_ctrl and lptr_datapath.
//
// Usage: requests (begin, move, end, tick) enter on the req_ valid/ready
// channel; results leave on the rsp_ valid/ready channel, last_of_run set on
// the final result of each request. Registers max_movement (index 0) and
// hold_ticks (index 1) are to be written through csr_ only while the block
// is idle; the block itself does not enforce it. One request is handled at
// a time. Begin, move and end walk the table, one slot per cycle; a move
// then runs the distance check (difference, squares, compare), and a move
// or end whose id is not held releases no result. A tick visits each slot
// in turn; an expiring touch is judged through the distance check and then
// released by an apply step. The result appears in the cycle after the step
// that releases it. A result is held back one step in a pending register so
// its end mark is known; the output register lets the next request be taken
// while the final result waits. When the receiver stalls, the walk stops
// before the pending register would overflow. Reset (synchronous) empties
// the table, clears both result registers and restores max_movement to 60
// and hold_ticks to 400.
`timescale 1ns / 1ps

module long_press_touch_recognizer_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  lptr_pkg::req_item_type          req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output lptr_pkg::rsp_item_type          rsp_data,
   input  logic                            csr_write_en,
   input  logic [lptr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lptr_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import lptr_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   lptr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_kind  (req_data.req_type),
      .stat      (stat),
      .cmd       (cmd)
   );

   lptr_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_data     (req_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cmd          (cmd),
      .stat         (stat),
      .rsp_ready    (rsp_ready),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp_data)
   );

   // A new request never finds a result of the previous one still pending.
   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> !stat.pend_valid)
      else $error("request accepted while a result is pending");

   // Releasing a result never overwrites one the receiver has not taken.
   a_apply_room: assert property (@(posedge clock) disable iff (reset)
      cmd.apply |-> (!stat.pend_valid || stat.out_free))
      else $error("pending result released into a full output register");

   // A flush of a pending result shows it with the end mark next cycle.
   a_flush_marks_last: assert property (@(posedge clock) disable iff (reset)
      (cmd.flush && stat.pend_valid) |=> (rsp_valid && rsp_data.last_of_run))
      else $error("final result missing its end mark");

   // After an apply step the new result is held pending.
   a_apply_pends: assert property (@(posedge clock) disable iff (reset)
      cmd.apply |=> stat.pend_valid)
      else $error("applied result lost");

endmodule

### hdl/lptr_datapath.sv
// Datapath of the long-press touch recognizer: slot table, configuration,
// distance pipeline, pending result and output register. Depends on lptr_pkg.
`timescale 1ns / 1ps

module lptr_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  lptr_pkg::req_item_type          req_data,
   input  logic                            csr_write_en,
   input  logic [lptr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lptr_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  lptr_pkg::dp_cmd_type            cmd,
   output lptr_pkg::dp_stat_type           stat,
   input  logic                            rsp_ready,
   output logic                            rsp_valid,
   output lptr_pkg::rsp_item_type          rsp_data
);
   import lptr_pkg::*;

   function automatic logic [POS_W-1:0] abs_diff(input logic [POS_W-1:0] a,
                                                 input logic [POS_W-1:0] b);
      abs_diff = (a > b) ? (a - b) : (b - a);
   endfunction

   // Configuration registers.
   logic [MOVE_W-1:0] max_move_ff, max_move_in;
   logic [CD_W-1:0]   hold_ticks_ff, hold_ticks_in;

   // Captured request.
   req_item_type req_ff, req_in;

   // Slot table.
   logic [MAX_TOUCHES-1:0] slot_valid_ff, slot_valid_in;
   logic [ID_W-1:0]  slot_touch_ff [MAX_TOUCHES];
   logic [ID_W-1:0]  slot_touch_in [MAX_TOUCHES];
   logic [POS_W-1:0] slot_ox_ff [MAX_TOUCHES];
   logic [POS_W-1:0] slot_ox_in [MAX_TOUCHES];
   logic [POS_W-1:0] slot_oy_ff [MAX_TOUCHES];
   logic [POS_W-1:0] slot_oy_in [MAX_TOUCHES];
   logic [POS_W-1:0] slot_lx_ff [MAX_TOUCHES];
   logic [POS_W-1:0] slot_lx_in [MAX_TOUCHES];
   logic [POS_W-1:0] slot_ly_ff [MAX_TOUCHES];
   logic [POS_W-1:0] slot_ly_in [MAX_TOUCHES];
   logic [CD_W-1:0]  slot_cd_ff [MAX_TOUCHES];
   logic [CD_W-1:0]  slot_cd_in [MAX_TOUCHES];

   // Walk index, lookup results and per-tick result count.
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic              match_found_ff, match_found_in;
   logic [SLOT_W-1:0] match_idx_ff, match_idx_in;
   logic              free_found_ff, free_found_in;
   logic [SLOT_W-1:0] free_idx_ff, free_idx_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   // Distance pipeline.
   logic [POS_W-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [SQ_W-1:0]  dx2_ff, dx2_in, dy2_ff, dy2_in, m2_ff, m2_in;
   logic             too_far_ff, too_far_in;

   // Pending result and output register.
   logic         pend_valid_ff, pend_valid_in;
   rsp_item_type pend_ff, pend_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_ff, rsp_in;

   logic              idx_last;
   logic [SLOT_W-1:0] idx_next;
   logic [POS_W-1:0]  ref_x, ref_y;
   rsp_item_type      new_item;

   assign idx_last = (idx_ff == SLOT_W'(MAX_TOUCHES - 1));
   assign idx_next = idx_last ? '0 : idx_ff + SLOT_W'(1);

   // Distance is from the origin to the request position, or to the last
   // position when a tick judges an expired touch.
   assign ref_x = (req_ff.req_type == REQ_TICK) ? slot_lx_ff[idx_ff] : req_ff.pos_x;
   assign ref_y = (req_ff.req_type == REQ_TICK) ? slot_ly_ff[idx_ff] : req_ff.pos_y;

   always_comb begin
      dx_in      = abs_diff(ref_x, slot_ox_ff[idx_ff]);
      dy_in      = abs_diff(ref_y, slot_oy_ff[idx_ff]);
      dx2_in     = SQ_W'(dx_ff) * SQ_W'(dx_ff);
      dy2_in     = SQ_W'(dy_ff) * SQ_W'(dy_ff);
      m2_in      = SQ_W'(max_move_ff) * SQ_W'(max_move_ff);
      too_far_in = ({1'b0, dx2_ff} + {1'b0, dy2_ff}) > {1'b0, m2_ff};
   end

   // Result that an apply step produces for the current slot.
   always_comb begin
      new_item              = '0;
      new_item.event_id     = req_ff.touch_id;
      new_item.origin_x_out = slot_ox_ff[idx_ff];
      new_item.origin_y_out = slot_oy_ff[idx_ff];
      case (req_ff.req_type)
         REQ_BEGIN: begin
            if (match_found_ff) begin
               new_item.event_kind = EV_STARTED;
            end else if (free_found_ff) begin
               new_item.event_kind   = EV_STARTED;
               new_item.origin_x_out = req_ff.pos_x;
               new_item.origin_y_out = req_ff.pos_y;
            end else begin
               new_item.event_kind   = EV_REJECTED;
               new_item.origin_x_out = '0;
               new_item.origin_y_out = '0;
            end
         end
         REQ_MOVE: begin
            new_item.event_kind = too_far_ff ? EV_CANCELED : EV_MOVED;
         end
         REQ_END: begin
            new_item.event_kind = EV_CANCELED;
         end
         default: begin
            new_item.event_kind = too_far_ff ? EV_CANCELED : EV_RECOGNIZED;
            new_item.event_id   = slot_touch_ff[idx_ff];
         end
      endcase
   end

   // Next-state logic of the table, walk state and result registers.
   always_comb begin
      max_move_in    = max_move_ff;
      hold_ticks_in  = hold_ticks_ff;
      req_in         = req_ff;
      slot_valid_in  = slot_valid_ff;
      slot_touch_in  = slot_touch_ff;
      slot_ox_in     = slot_ox_ff;
      slot_oy_in     = slot_oy_ff;
      slot_lx_in     = slot_lx_ff;
      slot_ly_in     = slot_ly_ff;
      slot_cd_in     = slot_cd_ff;
      idx_in         = idx_ff;
      match_found_in = match_found_ff;
      match_idx_in   = match_idx_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      cnt_in         = cnt_ff;
      pend_valid_in  = pend_valid_ff;
      pend_in        = pend_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_in         = rsp_ff;

      // The receiver takes the held result.
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // Configuration writes.
      if (csr_write_en) begin
         case (csr_index)
            CSR_MAX_MOVEMENT: max_move_in   = csr_wdata[MOVE_W-1:0];
            CSR_HOLD_TICKS:   hold_ticks_in = csr_wdata[CD_W-1:0];
            default: ;
         endcase
      end

      // Take a new request and restart the walk.
      if (cmd.capture) begin
         req_in         = req_data;
         idx_in         = '0;
         match_found_in = 1'b0;
         free_found_in  = 1'b0;
         cnt_in         = '0;
      end

      // Lookup walk: first slot holding the id and first free slot.
      if (cmd.scan) begin
         if (!match_found_ff && slot_valid_ff[idx_ff] &&
             (slot_touch_ff[idx_ff] == req_ff.touch_id)) begin
            match_found_in = 1'b1;
            match_idx_in   = idx_ff;
         end
         if (!free_found_ff && !slot_valid_ff[idx_ff]) begin
            free_found_in = 1'b1;
            free_idx_in   = idx_ff;
         end
         idx_in = idx_next;
      end

      if (cmd.target) begin
         idx_in = match_found_ff ? match_idx_ff : free_idx_ff;
      end

      // Tick walk on a slot that does not expire now.
      if (cmd.tick_step) begin
         if (slot_valid_ff[idx_ff]) begin
            slot_cd_in[idx_ff] = (slot_cd_ff[idx_ff] > CD_W'(1)) ?
                                 slot_cd_ff[idx_ff] - CD_W'(1) : CD_W'(1);
         end
         idx_in = idx_next;
      end

      // Produce a result and update the slot it refers to.
      if (cmd.apply) begin
         if (pend_valid_ff) begin
            rsp_in             = pend_ff;
            rsp_in.last_of_run = 1'b0;
            rsp_valid_in       = 1'b1;
         end
         pend_in       = new_item;
         pend_valid_in = 1'b1;
         case (req_ff.req_type)
            REQ_BEGIN: begin
               if (!match_found_ff && free_found_ff) begin
                  slot_valid_in[idx_ff] = 1'b1;
                  slot_touch_in[idx_ff] = req_ff.touch_id;
                  slot_ox_in[idx_ff]    = req_ff.pos_x;
                  slot_oy_in[idx_ff]    = req_ff.pos_y;
                  slot_lx_in[idx_ff]    = req_ff.pos_x;
                  slot_ly_in[idx_ff]    = req_ff.pos_y;
                  slot_cd_in[idx_ff]    = hold_ticks_ff;
               end
            end
            REQ_MOVE: begin
               if (too_far_ff) begin
                  slot_valid_in[idx_ff] = 1'b0;
               end else begin
                  slot_lx_in[idx_ff] = req_ff.pos_x;
                  slot_ly_in[idx_ff] = req_ff.pos_y;
               end
            end
            REQ_END: begin
               slot_valid_in[idx_ff] = 1'b0;
            end
            default: begin
               slot_valid_in[idx_ff] = 1'b0;
               cnt_in                = cnt_ff + CNT_W'(1);
               idx_in                = idx_next;
            end
         endcase
      end

      // Release the final result of the request with its end mark.
      if (cmd.flush && pend_valid_ff) begin
         rsp_in             = pend_ff;
         rsp_in.last_of_run = 1'b1;
         rsp_valid_in       = 1'b1;
         pend_valid_in      = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_move_ff    <= MAX_MOVE_RESET;
         hold_ticks_ff  <= HOLD_TICKS_RESET;
         slot_valid_ff  <= '0;
         idx_ff         <= '0;
         match_found_ff <= 1'b0;
         free_found_ff  <= 1'b0;
         cnt_ff         <= '0;
         pend_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         max_move_ff    <= max_move_in;
         hold_ticks_ff  <= hold_ticks_in;
         slot_valid_ff  <= slot_valid_in;
         idx_ff         <= idx_in;
         match_found_ff <= match_found_in;
         free_found_ff  <= free_found_in;
         cnt_ff         <= cnt_in;
         pend_valid_ff  <= pend_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      slot_touch_ff <= slot_touch_in;
      slot_ox_ff    <= slot_ox_in;
      slot_oy_ff    <= slot_oy_in;
      slot_lx_ff    <= slot_lx_in;
      slot_ly_ff    <= slot_ly_in;
      slot_cd_ff    <= slot_cd_in;
      match_idx_ff  <= match_idx_in;
      free_idx_ff   <= free_idx_in;
      dx_ff         <= dx_in;
      dy_ff         <= dy_in;
      dx2_ff        <= dx2_in;
      dy2_ff        <= dy2_in;
      m2_ff         <= m2_in;
      too_far_ff    <= too_far_in;
      pend_ff       <= pend_in;
      rsp_ff        <= rsp_in;
   end

   // Status toward the controller.
   always_comb begin
      stat.req_kind   = req_ff.req_type;
      stat.cur_valid  = slot_valid_ff[idx_ff];
      stat.cur_cd_gt1 = slot_cd_ff[idx_ff] > CD_W'(1);
      stat.cnt_full   = cnt_ff >= CNT_W'(MAX_RESULTS);
      stat.idx_last   = idx_last;
      stat.has_match  = match_found_ff;
      stat.pend_valid = pend_valid_ff;
      stat.out_free   = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### hdl/lptr_ctrl.sv
// Controller of the long-press touch recognizer: sequences lookup walks,
// tick walks, distance checks and result release. Depends on lptr_pkg.
`timescale 1ns / 1ps

module lptr_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [lptr_pkg::KIND_W-1:0]  req_kind,
   input  lptr_pkg::dp_stat_type        stat,
   output lptr_pkg::dp_cmd_type         cmd
);
   import lptr_pkg::*;

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_SCAN   = 9'b000000010,
      S_TARGET = 9'b000000100,
      S_TICK   = 9'b000001000,
      S_DIST   = 9'b000010000,
      S_MULT   = 9'b000100000,
      S_CMP    = 9'b001000000,
      S_APPLY  = 9'b010000000,
      S_FLUSH  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = (req_kind == REQ_TICK) ? S_TICK : S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.idx_last) begin
               state_in = S_TARGET;
            end
         end
         S_TARGET: begin
            cmd.target = 1'b1;
            case (stat.req_kind)
               REQ_BEGIN: state_in = S_APPLY;
               REQ_MOVE:  state_in = stat.has_match ? S_DIST : S_FLUSH;
               REQ_END:   state_in = stat.has_match ? S_APPLY : S_FLUSH;
               default:   state_in = S_FLUSH;
            endcase
         end
         S_TICK: begin
            // An expiring slot is judged unless the result limit is reached.
            if (stat.cur_valid && !stat.cur_cd_gt1 && !stat.cnt_full) begin
               state_in = S_DIST;
            end else begin
               cmd.tick_step = 1'b1;
               if (stat.idx_last) begin
                  state_in = S_FLUSH;
               end
            end
         end
         S_DIST: state_in = S_MULT;
         S_MULT: state_in = S_CMP;
         S_CMP:  state_in = S_APPLY;
         S_APPLY: begin
            // The pending result must have room in the output register.
            if (!stat.pend_valid || stat.out_free) begin
               cmd.apply = 1'b1;
               if (stat.req_kind == REQ_TICK) begin
                  state_in = stat.idx_last ? S_FLUSH : S_TICK;
               end else begin
                  state_in = S_FLUSH;
               end
            end
         end
         S_FLUSH: begin
            if (!stat.pend_valid) begin
               state_in = S_IDLE;
            end else if (stat.out_free) begin
               cmd.flush = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### verif/tb_top.sv
// Self-checking testbench for the long-press touch recognizer unit.
// Depends on lptr_pkg and long_press_touch_recognizer_unit. It predicts every result
// from its own copy of the touch table and checks each one as it leaves the block.
`timescale 1ns / 1ps

module tb_top;
   import lptr_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 5 * MAX_TOUCHES + 8;
   localparam int ID_POOL_TOP  = 11;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_item_type req_data;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_item_type rsp_data;
   logic                  csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // Predicted touch table and register copies.
   logic              touch_held [MAX_TOUCHES];
   logic [ID_W-1:0]   touch_tag  [MAX_TOUCHES];
   logic [POS_W-1:0]  origin_x   [MAX_TOUCHES];
   logic [POS_W-1:0]  origin_y   [MAX_TOUCHES];
   logic [POS_W-1:0]  last_x     [MAX_TOUCHES];
   logic [POS_W-1:0]  last_y     [MAX_TOUCHES];
   logic [CD_W-1:0]   hold_left  [MAX_TOUCHES];
   logic [MOVE_W-1:0] reach_limit;
   logic [CD_W-1:0]   hold_setting;

   rsp_item_type pending_events [$];
   rsp_item_type want_event;

   bit steady;
   int error_count;
   int requests_sent;
   int settings_used;
   int results_checked;
   int cycle_count;
   int kind_count [8];

   long_press_touch_recognizer_unit u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The receiver stalls about 27 times in a hundred, except in the steady phase.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready = steady || ($urandom_range(99) >= 27);
      end
   end

   // Run guard.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Run stopped at cycle %0d with %0d results outstanding.",
                  cycle_count, pending_events.size());
         $display("tb_top NOT OK");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      error_count++;
      $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
   endtask

   // Compare every accepted result with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (pending_events.size() == 0) begin
            report_mismatch("result with none outstanding (kind)", '0,
                            32'(rsp_data.event_kind));
         end else begin
            want_event = pending_events.pop_front();
            if (rsp_data.event_kind !== want_event.event_kind)
               report_mismatch("event_kind", 32'(want_event.event_kind),
                               32'(rsp_data.event_kind));
            if (rsp_data.event_id !== want_event.event_id)
               report_mismatch("event_id", 32'(want_event.event_id),
                               32'(rsp_data.event_id));
            if (rsp_data.origin_x_out !== want_event.origin_x_out)
               report_mismatch("origin_x_out", 32'(want_event.origin_x_out),
                               32'(rsp_data.origin_x_out));
            if (rsp_data.origin_y_out !== want_event.origin_y_out)
               report_mismatch("origin_y_out", 32'(want_event.origin_y_out),
                               32'(rsp_data.origin_y_out));
            if (rsp_data.last_of_run !== want_event.last_of_run)
               report_mismatch("last_of_run", 32'(want_event.last_of_run),
                               32'(rsp_data.last_of_run));
            results_checked++;
            kind_count[want_event.event_kind]++;
         end
      end
   end

   function automatic int find_touch(input logic [ID_W-1:0] id);
      for (int s = 0; s < MAX_TOUCHES; s++) begin
         if (touch_held[s] && touch_tag[s] == id)
            return s;
      end
      return -1;
   endfunction

   // Squared travel from the origin is compared exactly with the squared limit.
   function automatic bit too_far(input int s, input logic [POS_W-1:0] x,
                                  input logic [POS_W-1:0] y);
      int unsigned dx;
      int unsigned dy;
      int unsigned r;
      dx = 32'((x > origin_x[s]) ? x - origin_x[s] : origin_x[s] - x);
      dy = 32'((y > origin_y[s]) ? y - origin_y[s] : origin_y[s] - y);
      r  = 32'(reach_limit);
      return (dx * dx + dy * dy) > r * r;
   endfunction

   function automatic rsp_item_type make_event(input logic [EVENT_W-1:0] kind,
                                               input logic [ID_W-1:0] id,
                                               input logic [POS_W-1:0] ox,
                                               input logic [POS_W-1:0] oy);
      rsp_item_type ev;
      ev.event_kind   = kind;
      ev.event_id     = id;
      ev.origin_x_out = ox;
      ev.origin_y_out = oy;
      ev.last_of_run  = 1'b0;
      return ev;
   endfunction

   // Update the predicted table for one accepted request and queue its results.
   function automatic void predict_gesture_events(input req_item_type item);
      rsp_item_type batch [MAX_RESULTS];
      int n;
      int s;
      n = 0;
      s = find_touch(item.touch_id);
      case (item.req_type)
         REQ_BEGIN: begin
            if (s >= 0) begin
               batch[n] = make_event(EV_STARTED, item.touch_id, origin_x[s], origin_y[s]);
               n++;
            end else begin
               s = 0;
               while (s < MAX_TOUCHES && touch_held[s])
                  s++;
               if (s >= MAX_TOUCHES) begin
                  batch[n] = make_event(EV_REJECTED, item.touch_id, '0, '0);
               end else begin
                  touch_held[s] = 1'b1;
                  touch_tag[s]  = item.touch_id;
                  origin_x[s]   = item.pos_x;
                  origin_y[s]   = item.pos_y;
                  last_x[s]     = item.pos_x;
                  last_y[s]     = item.pos_y;
                  hold_left[s]  = hold_setting;
                  batch[n] = make_event(EV_STARTED, item.touch_id, item.pos_x, item.pos_y);
               end
               n++;
            end
         end
         REQ_MOVE: begin
            if (s >= 0) begin
               if (too_far(s, item.pos_x, item.pos_y)) begin
                  batch[n] = make_event(EV_CANCELED, item.touch_id, origin_x[s], origin_y[s]);
                  touch_held[s] = 1'b0;
               end else begin
                  last_x[s] = item.pos_x;
                  last_y[s] = item.pos_y;
                  batch[n] = make_event(EV_MOVED, item.touch_id, origin_x[s], origin_y[s]);
               end
               n++;
            end
         end
         REQ_END: begin
            if (s >= 0) begin
               batch[n] = make_event(EV_CANCELED, item.touch_id, origin_x[s], origin_y[s]);
               touch_held[s] = 1'b0;
               n++;
            end
         end
         default: begin
            // Tick: count every held touch down in slot order and judge expiries.
            for (int t = 0; t < MAX_TOUCHES; t++) begin
               if (!touch_held[t])
                  continue;
               if (hold_left[t] > 1) begin
                  hold_left[t] = hold_left[t] - 1'b1;
               end else if (n >= MAX_RESULTS) begin
                  hold_left[t] = CD_W'(1);
               end else begin
                  batch[n] = make_event(too_far(t, last_x[t], last_y[t]) ? EV_CANCELED
                                                                          : EV_RECOGNIZED,
                                        touch_tag[t], origin_x[t], origin_y[t]);
                  touch_held[t] = 1'b0;
                  n++;
               end
            end
         end
      endcase
      if (n > 0) begin
         batch[n-1].last_of_run = 1'b1;
         for (int i = 0; i < n; i++)
            pending_events.push_back(batch[i]);
      end
   endfunction

   function automatic req_item_type pack_request(input logic [KIND_W-1:0] kind,
                                                 input logic [ID_W-1:0] id,
                                                 input logic [POS_W-1:0] x,
                                                 input logic [POS_W-1:0] y);
      req_item_type item;
      item.req_type = kind;
      item.touch_id = id;
      item.pos_x    = x;
      item.pos_y    = y;
      return item;
   endfunction

   // A position within span pixels of center, clipped to the screen.
   function automatic logic [POS_W-1:0] near_position(input int center, input int span);
      int p;
      p = center + int'($urandom_range(2 * span)) - span;
      if (p < 0)
         p = 0;
      if (p > 4095)
         p = 4095;
      return p[POS_W-1:0];
   endfunction

   // Mostly gestures on held touches from a small id pool, with some stray ids.
   function automatic req_item_type make_random_request();
      req_item_type item;
      int held_slots [$];
      int roll;
      int s;
      int span;
      item.touch_id = ($urandom_range(99) < 85) ? ID_W'($urandom_range(ID_POOL_TOP))
                                                 : ID_W'($urandom);
      item.pos_x = POS_W'($urandom);
      item.pos_y = POS_W'($urandom);
      for (int t = 0; t < MAX_TOUCHES; t++) begin
         if (touch_held[t])
            held_slots.push_back(t);
      end
      roll = $urandom_range(99);
      if (roll < 30) begin
         item.req_type = REQ_BEGIN;
      end else if (roll < 60) begin
         item.req_type = REQ_MOVE;
         if (held_slots.size() > 0 && $urandom_range(99) < 75) begin
            s    = held_slots[$urandom_range(held_slots.size() - 1)];
            span = int'(reach_limit) + int'(reach_limit) / 4 + 2;
            item.touch_id = touch_tag[s];
            item.pos_x    = near_position(int'(origin_x[s]), span);
            item.pos_y    = near_position(int'(origin_y[s]), span);
         end
      end else if (roll < 70) begin
         item.req_type = REQ_END;
         if (held_slots.size() > 0 && $urandom_range(99) < 70)
            item.touch_id = touch_tag[held_slots[$urandom_range(held_slots.size() - 1)]];
      end else begin
         item.req_type = REQ_TICK;
      end
      return item;
   endfunction

   // Send one request, with a random gap before it outside the steady phase.
   // The gap can outlast a table walk so the block also sees idle cycles.
   task automatic send_request(input req_item_type item);
      int gap;
      gap = (!steady && $urandom_range(99) < 27) ?
            $urandom_range(1, 2 * MAX_TOUCHES + 8) : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_data  = item;
      do @(posedge clock); while (req_ready !== 1'b1);
      requests_sent++;
      predict_gesture_events(item);
   endtask

   // Wait until every predicted result has left and the block has finished its walk.
   task automatic wait_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_events.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic program_register(input logic [CSR_IDX_W-1:0] idx,
                                   input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_write_en = 1'b1;
      csr_index    = idx;
      csr_wdata    = value;
      @(negedge clock);
      csr_write_en = 1'b0;
      if (idx == CSR_MAX_MOVEMENT)
         reach_limit = value[MOVE_W-1:0];
      else
         hold_setting = value;
      settings_used++;
   endtask

   // New touches at both corners, then a begin for an id that is already held.
   task automatic test_begin_and_duplicate();
      send_request(pack_request(REQ_BEGIN, 8'd0, 12'd0, 12'd0));
      send_request(pack_request(REQ_BEGIN, 8'd255, 12'd4095, 12'd4095));
      send_request(pack_request(REQ_BEGIN, 8'd0, 12'd123, 12'd456));
   endtask

   // Moves inside, on and beyond the limit, an end, and both for an unknown id.
   task automatic test_move_and_end();
      send_request(pack_request(REQ_MOVE, 8'd255, 12'd4065, 12'd4065));
      send_request(pack_request(REQ_MOVE, 8'd255, 12'd4000, 12'd4000));
      send_request(pack_request(REQ_MOVE, 8'd0, 12'd60, 12'd0));
      send_request(pack_request(REQ_END, 8'd0, 12'd0, 12'd0));
      send_request(pack_request(REQ_MOVE, 8'd77, 12'd1, 12'd1));
      send_request(pack_request(REQ_END, 8'd77, 12'd1, 12'd1));
   endtask

   // Fill the table, get a rejection, then expire every touch on the second of two ticks.
   task automatic test_table_full();
      wait_idle();
      program_register(CSR_HOLD_TICKS, 16'd2);
      for (int i = 1; i <= MAX_TOUCHES; i++)
         send_request(pack_request(REQ_BEGIN, ID_W'(i), POS_W'(i * 455),
                                   POS_W'(4095 - i * 455)));
      send_request(pack_request(REQ_BEGIN, 8'd9, 12'd4095, 12'd0));
      send_request(pack_request(REQ_TICK, 8'hA5, 12'hFFF, 12'h000));
      send_request(pack_request(REQ_TICK, 8'h5A, 12'h000, 12'hFFF));
   endtask

   // A touch that stayed in range is canceled at expiry once the limit shrinks.
   task automatic test_cancel_on_expiry();
      wait_idle();
      program_register(CSR_MAX_MOVEMENT, 16'd100);
      program_register(CSR_HOLD_TICKS, 16'd1);
      send_request(pack_request(REQ_BEGIN, 8'h5A, 12'd2048, 12'd2048));
      send_request(pack_request(REQ_MOVE, 8'h5A, 12'd2118, 12'd2118));
      wait_idle();
      program_register(CSR_MAX_MOVEMENT, 16'd10);
      send_request(pack_request(REQ_TICK, 8'h00, 12'd0, 12'd0));
   endtask

   // A hold of zero ticks behaves as one tick.
   task automatic test_zero_hold();
      wait_idle();
      program_register(CSR_HOLD_TICKS, 16'd0);
      send_request(pack_request(REQ_BEGIN, 8'd3, 12'd7, 12'd9));
      send_request(pack_request(REQ_TICK, 8'hFF, 12'hABC, 12'h543));
   endtask

   task automatic test_random_traffic(input int count, input logic [MOVE_W-1:0] reach,
                                      input logic [CD_W-1:0] hold, input bit no_idle);
      wait_idle();
      program_register(CSR_MAX_MOVEMENT, CSR_DATA_W'(reach));
      program_register(CSR_HOLD_TICKS, hold);
      steady = no_idle;
      for (int i = 0; i < count; i++)
         send_request(make_random_request());
   endtask

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      csr_write_en = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      steady       = 1'b0;
      reach_limit  = MAX_MOVE_RESET;
      hold_setting = HOLD_TICKS_RESET;
      for (int s = 0; s < MAX_TOUCHES; s++)
         touch_held[s] = 1'b0;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      test_begin_and_duplicate();
      test_move_and_end();
      test_table_full();
      test_cancel_on_expiry();
      test_zero_hold();
      test_random_traffic(120, MOVE_W'($urandom_range(20, 300)),
                          CD_W'($urandom_range(2, 6)), 1'b0);
      test_random_traffic(40, '0, 16'd1, 1'b0);
      test_random_traffic(80, MOVE_W'($urandom_range(30, 200)), 16'd3, 1'b1);
      test_random_traffic(40, 12'd4095, 16'd65535, 1'b0);
      wait_idle();

      $display("Sent %0d requests across %0d register writes; checked %0d results.",
               requests_sent, settings_used, results_checked);
      $display("Started %0d, moved %0d, canceled %0d, recognized %0d, rejected %0d.",
               kind_count[EV_STARTED], kind_count[EV_MOVED], kind_count[EV_CANCELED],
               kind_count[EV_RECOGNIZED], kind_count[EV_REJECTED]);
      if (error_count == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
